// File: sv/etq_pkg.sv
// etq_pkg: shared types and codes for the expiry timer queue.
// No dependencies; compiled first.
package etq_pkg;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_ADJUST = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_TICK   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_DUP      = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DECIDE,
        S_MV_RD,
        S_MV_WR,
        S_PUT,
        S_DONE,
        S_TICK_RD,
        S_TICK_CMP,
        S_TICK_END,
        S_EMIT_RD,
        S_EMIT_OUT
    } state_t;

    typedef struct packed {
        status_t     status;
        logic        expired_valid;
        logic [15:0] expired_handle;
        logic        last;
        logic [5:0]  occupancy;
    } res_t;

endpackage

// File: sv/etq_if.sv
// etq_in_if / etq_out_if: valid/ready channels of the expiry timer queue.
// Depends on nothing; a transfer happens when valid and ready are both high.
interface etq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] handle;
    logic [31:0] expire;
    logic [31:0] current_time;
    modport source (output valid, mode, handle, expire, current_time, input ready);
    modport sink   (input valid, mode, handle, expire, current_time, output ready);
endinterface

interface etq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        expired_valid;
    logic [15:0] expired_handle;
    logic        last;
    logic [5:0]  occupancy;
    modport source (output valid, status, expired_valid, expired_handle, last, occupancy,
                    input ready);
    modport sink   (input valid, status, expired_valid, expired_handle, last, occupancy,
                    output ready);
endinterface

// File: sv/expiry_timer_queue.sv
// expiry_timer_queue: top level; sequencer, entry RAM and output stage.
// Depends on etq_pkg, etq_if, etq_ram and etq_seq.
//
// Sorted timer queue of up to DEPTH entries (16-bit handle, TIME_BITS-bit
// expiry) held in one RAM as a circular list; slot 0 is the head. Add, adjust
// and delete first scan every entry to find the handle and the insert point,
// then shift the entries between the old and new place one at a time. Tick
// scans the expired prefix and then delivers one transfer per popped handle,
// waiting while the sink holds ready low; the pops themselves only move the
// head pointer. Every operation ends in at least one result transfer;
// occupancy on each result is the count after the whole operation. Input
// ready is high whenever the sequencer is idle, even while the last result
// waits in the output stage.
// No clearing pass after reset: only slots below the count are ever read.
module expiry_timer_queue #(
    parameter int DEPTH     = 32,
    parameter int TIME_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    etq_in_if.sink    in_ch,
    etq_out_if.source out_ch
);
    import etq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int EW = 16 + TIME_BITS;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;
    logic          res_load;
    logic          res_ready;
    res_t          res;
    logic          out_valid_reg;
    res_t          out_reg;

    // output stage can take a result when empty or draining this cycle
    assign res_ready = !out_valid_reg || out_ch.ready;

    etq_seq #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_mode   (mode_t'(in_ch.mode)),
        .in_handle (in_ch.handle),
        .in_expire (in_ch.expire),
        .in_now    (in_ch.current_time),
        .res_ready (res_ready),
        .res_load  (res_load),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    etq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_reg <= res;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.status         = out_reg.status;
    assign out_ch.expired_valid  = out_reg.expired_valid;
    assign out_ch.expired_handle = out_reg.expired_handle;
    assign out_ch.last           = out_reg.last;
    assign out_ch.occupancy      = out_reg.occupancy;
endmodule

// File: sv/etq_ram.sv
// etq_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module etq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: sv/etq_seq.sv
// etq_seq: sequencer of the timer queue; scans, shifts and pops entries in the RAM.
// Depends on etq_pkg; drives etq_ram through its ports.
module etq_seq #(
    parameter int DEPTH     = 32,
    parameter int TIME_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  etq_pkg::mode_t                in_mode,
    input  logic [15:0]                   in_handle,
    input  logic [31:0]                   in_expire,
    input  logic [31:0]                   in_now,
    input  logic                          res_ready,
    output logic                          res_load,
    output etq_pkg::res_t                 res,
    output logic                          ram_we,
    output logic [$clog2(DEPTH)-1:0]      ram_waddr,
    output logic [16+TIME_BITS-1:0]       ram_wdata,
    output logic                          ram_re,
    output logic [$clog2(DEPTH)-1:0]      ram_raddr,
    input  logic [16+TIME_BITS-1:0]       ram_rdata
);
    import etq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    state_t               state_reg, state_next;
    mode_t                mode_reg, mode_next;
    status_t              status_reg, status_next;
    logic [15:0]          hdl_reg, hdl_next;
    logic [TIME_BITS-1:0] exp_reg, exp_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        i_reg, i_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        q_reg, q_next;
    logic [CW-1:0]        cur_reg, cur_next;
    logic [CW-1:0]        end_reg, end_next;
    logic                 found_reg, found_next;
    logic                 down_reg, down_next;
    logic                 put_reg, put_next;

    logic [15:0]          rd_hdl;
    logic [TIME_BITS-1:0] rd_exp;
    logic [CW-1:0]        src;
    logic                 mv_done;
    logic                 emit_last;
    status_t              dec_status;

    // logical slot to RAM address, relative to the circular head
    function automatic logic [AW-1:0] phys(input logic [CW-1:0] l, input logic [AW-1:0] h);
        logic [CW:0] s;
        s = {1'b0, l} + (CW+1)'(h);
        if (s >= (CW+1)'(DEPTH))
        begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign rd_hdl    = ram_rdata[16+TIME_BITS-1:TIME_BITS];
    assign rd_exp    = ram_rdata[TIME_BITS-1:0];
    assign src       = down_reg ? cur_reg + CW'(1) : cur_reg - CW'(1);
    assign mv_done   = down_reg ? (cur_reg >= end_reg) : (cur_reg <= end_reg);
    assign emit_last = (cur_reg == i_reg - CW'(1));

    always_comb
    begin
        dec_status = ST_OK;
        if (mode_reg == MODE_ADD)
        begin
            if (found_reg)
                dec_status = ST_DUP;
            else if (count_reg == CW'(DEPTH))
                dec_status = ST_FULL;
        end
        else if (!found_reg)
        begin
            dec_status = ST_NOTFOUND;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (in_valid) state_next = (mode_t'(in_mode) == MODE_TICK) ?
                                                   S_TICK_RD : S_SCAN_RD;
            S_SCAN_RD:  state_next = (i_reg == count_reg) ? S_DECIDE : S_SCAN_CMP;
            S_SCAN_CMP: state_next = S_SCAN_RD;
            S_DECIDE:   state_next = (dec_status != ST_OK) ? S_DONE : S_MV_RD;
            S_MV_RD:    state_next = mv_done ? (put_reg ? S_PUT : S_DONE) : S_MV_WR;
            S_MV_WR:    state_next = S_MV_RD;
            S_PUT:      state_next = S_DONE;
            S_DONE:     if (res_ready) state_next = S_IDLE;
            S_TICK_RD:  state_next = (i_reg == count_reg) ? S_TICK_END : S_TICK_CMP;
            S_TICK_CMP: state_next = (rd_exp <= now_reg) ? S_TICK_RD : S_TICK_END;
            S_TICK_END: state_next = (i_reg == '0) ? S_DONE : S_EMIT_RD;
            S_EMIT_RD:  state_next = S_EMIT_OUT;
            S_EMIT_OUT: if (res_ready) state_next = emit_last ? S_IDLE : S_EMIT_RD;
            default:    state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = 1'b0;
        res_load  = 1'b0;
        res       = '{status: status_reg, expired_valid: 1'b0, expired_handle: 16'd0,
                      last: 1'b1, occupancy: 6'(count_reg)};
        ram_we    = 1'b0;
        ram_waddr = phys(cur_reg, head_reg);
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = phys(i_reg, head_reg);
        unique case (state_reg)
            S_IDLE:    in_ready = 1'b1;
            S_SCAN_RD, S_TICK_RD: ram_re = (i_reg != count_reg);
            S_MV_RD:
            begin
                ram_re    = !mv_done;
                ram_raddr = phys(src, head_reg);
            end
            S_MV_WR:   ram_we = 1'b1;
            S_PUT:
            begin
                ram_we    = 1'b1;
                ram_waddr = phys(q_reg, head_reg);
                ram_wdata = {hdl_reg, exp_reg};
            end
            S_DONE:    res_load = res_ready;
            S_EMIT_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = phys(cur_reg, head_reg);
            end
            S_EMIT_OUT:
            begin
                res_load = res_ready;
                res = '{status: ST_OK, expired_valid: 1'b1, expired_handle: rd_hdl,
                        last: emit_last, occupancy: 6'(count_reg)};
            end
            default: ;
        endcase
    end

    // datapath registers
    always_comb
    begin
        mode_next   = mode_reg;
        status_next = status_reg;
        hdl_next    = hdl_reg;
        exp_next    = exp_reg;
        now_next    = now_reg;
        count_next  = count_reg;
        head_next   = head_reg;
        i_next      = i_reg;
        pos_next    = pos_reg;
        q_next      = q_reg;
        cur_next    = cur_reg;
        end_next    = end_reg;
        found_next  = found_reg;
        down_next   = down_reg;
        put_next    = put_reg;
        case (state_reg)
            S_IDLE:
            begin
                mode_next   = mode_t'(in_mode);
                hdl_next    = in_handle;
                exp_next    = TIME_BITS'(in_expire);
                now_next    = TIME_BITS'(in_now);
                status_next = ST_OK;
                i_next      = '0;
                q_next      = '0;
                found_next  = 1'b0;
            end
            S_SCAN_CMP:
            begin
                i_next = i_reg + CW'(1);
                if (rd_hdl == hdl_reg)
                begin
                    found_next = 1'b1;
                    pos_next   = i_reg;
                end
                else if (rd_exp <= exp_reg)
                begin
                    q_next = q_reg + CW'(1);
                end
            end
            S_DECIDE:
            begin
                status_next = dec_status;
                if (dec_status == ST_OK)
                begin
                    unique case (mode_reg)
                        MODE_ADD:
                        begin
                            down_next  = 1'b0;
                            cur_next   = count_reg;
                            end_next   = q_reg;
                            put_next   = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                        MODE_DELETE:
                        begin
                            down_next  = 1'b1;
                            cur_next   = pos_reg;
                            end_next   = count_reg - CW'(1);
                            put_next   = 1'b0;
                            count_next = count_reg - CW'(1);
                        end
                        default:
                        begin
                            down_next = (q_reg >= pos_reg);
                            cur_next  = pos_reg;
                            end_next  = q_reg;
                            put_next  = 1'b1;
                        end
                    endcase
                end
            end
            S_MV_WR:    cur_next = down_reg ? cur_reg + CW'(1) : cur_reg - CW'(1);
            S_TICK_CMP: if (rd_exp <= now_reg) i_next = i_reg + CW'(1);
            S_TICK_END:
            begin
                count_next = count_reg - i_reg;
                cur_next   = '0;
            end
            S_EMIT_OUT:
            begin
                if (res_ready)
                begin
                    cur_next = cur_reg + CW'(1);
                    if (emit_last)
                        head_next = phys(i_reg, head_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        status_reg <= status_next;
        hdl_reg    <= hdl_next;
        exp_reg    <= exp_next;
        now_reg    <= now_next;
        i_reg      <= i_next;
        pos_reg    <= pos_next;
        q_reg      <= q_next;
        cur_reg    <= cur_next;
        end_reg    <= end_next;
        found_reg  <= found_next;
        down_reg   <= down_next;
        put_reg    <= put_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> res_ready)
        else $error("result loaded into busy output stage");
    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MV_WR |-> $past(state_reg) == S_MV_RD)
        else $error("shift write without preceding read");
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, head_reg} < (AW+1)'(DEPTH))
        else $error("head pointer out of range");
endmodule
